// File: src/polygon_fan_triangle_indexer_assert.svh
// Assertion macros for the fan triangle indexer checker
`ifndef POLYGON_FAN_TRIANGLE_INDEXER_ASSERT_SVH
`define POLYGON_FAN_TRIANGLE_INDEXER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PFTI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfti assertion failed");

// next-cycle implication
`define PFTI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfti assertion failed");

`endif

// File: src/pfti_pkg.sv
// Types and constants shared by the fan triangle indexer
`default_nettype none

package pfti_pkg;

    localparam int IndexBits = 31;
    localparam int CountBits = 16;
    localparam int FaceBits  = 30;
    localparam int PaddrBits = 3;
    localparam int PdataBits = 32;

    localparam logic [PaddrBits-1:0] CfgAddrFlip = 3'd0;

    localparam logic FuncHeader = 1'b0;
    localparam logic FuncVertex = 1'b1;

    localparam logic [1:0] HideNone  = 2'd0;
    localparam logic [1:0] HideFirst = 2'd1;
    localparam logic [1:0] HideLast  = 2'd2;
    localparam logic [1:0] HideBoth  = 2'd3;

    typedef struct packed {
        logic                 func;
        logic [CountBits-1:0] face_vertex_count;
        logic                 face_is_hole;
        logic [IndexBits-1:0] vertex_index;
    } item_t;

    typedef struct packed {
        logic [IndexBits-1:0] corner_a;
        logic [IndexBits-1:0] corner_b;
        logic [IndexBits-1:0] corner_c;
        logic [FaceBits-1:0]  source_face;
        logic [1:0]           hidden_edges;
        logic [IndexBits-1:0] edge_number;
    } result_t;

    typedef enum logic [1:0] {
        FAN_SINGLE,
        FAN_FIRST,
        FAN_MIDDLE,
        FAN_LAST
    } fan_kind_t;

    // one classified triangle, handed from front to back
    typedef struct packed {
        logic [IndexBits-1:0] origin;
        logic [IndexBits-1:0] prev;
        logic [IndexBits-1:0] cur;
        logic [FaceBits-1:0]  face;
        fan_kind_t            kind;
        logic [IndexBits-1:0] base;
        logic [CountBits-1:0] tri_num;
    } job_t;

endpackage

`default_nettype wire

// File: src/pfti_front.sv
// Front end: takes words, tracks face state, classifies fan triangles
`default_nettype none

module pfti_front (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               item_valid,
    output logic              item_ready,
    input  pfti_pkg::item_t   item_data,
    input  wire               queue_full,
    output logic              job_push,
    output pfti_pkg::job_t    job_data
);
    import pfti_pkg::*;

    logic                 header_seen_reg, header_seen_next;
    logic [FaceBits-1:0]  face_counter_reg, face_counter_next;
    logic [CountBits-1:0] face_size_reg, face_size_next;
    logic                 hole_mark_reg, hole_mark_next;
    logic [CountBits-1:0] vertex_position_reg, vertex_position_next;
    logic [IndexBits-1:0] edge_base_reg, edge_base_next;
    logic [IndexBits-1:0] fan_origin_reg, fan_origin_next;
    logic [IndexBits-1:0] previous_vertex_reg, previous_vertex_next;

    logic accept;
    logic live;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        header_seen_next     = header_seen_reg;
        face_counter_next    = face_counter_reg;
        face_size_next       = face_size_reg;
        hole_mark_next       = hole_mark_reg;
        vertex_position_next = vertex_position_reg;
        edge_base_next       = edge_base_reg;
        fan_origin_next      = fan_origin_reg;
        previous_vertex_next = previous_vertex_reg;
        job_push             = 1'b0;
        live                 = header_seen_reg && (vertex_position_reg < face_size_reg);

        job_data.origin  = fan_origin_reg;
        job_data.prev    = previous_vertex_reg;
        job_data.cur     = item_data.vertex_index;
        job_data.face    = face_counter_reg;
        job_data.base    = edge_base_reg;
        job_data.tri_num = vertex_position_reg - CountBits'(2);
        if (face_size_reg == CountBits'(3))
            job_data.kind = FAN_SINGLE;
        else if (vertex_position_reg == CountBits'(2))
            job_data.kind = FAN_FIRST;
        else if (vertex_position_reg == face_size_reg - CountBits'(1))
            job_data.kind = FAN_LAST;
        else
            job_data.kind = FAN_MIDDLE;

        if (accept)
        begin
            if (item_data.func == FuncHeader)
            begin
                // the first header keeps face 0 and base 0
                if (header_seen_reg)
                begin
                    face_counter_next = face_counter_reg + FaceBits'(1);
                    edge_base_next    = edge_base_reg + IndexBits'(face_size_reg);
                end
                header_seen_next     = 1'b1;
                face_size_next       = item_data.face_vertex_count;
                hole_mark_next       = item_data.face_is_hole;
                vertex_position_next = '0;
            end
            else if (live)
            begin
                vertex_position_next = vertex_position_reg + CountBits'(1);
                previous_vertex_next = item_data.vertex_index;
                if (vertex_position_reg == '0)
                    fan_origin_next = item_data.vertex_index;
                job_push = (vertex_position_reg >= CountBits'(2))
                        && (face_size_reg >= CountBits'(3)) && !hole_mark_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_seen_reg     <= 1'b0;
            face_counter_reg    <= '0;
            face_size_reg       <= '0;
            hole_mark_reg       <= 1'b0;
            vertex_position_reg <= '0;
            edge_base_reg       <= '0;
            fan_origin_reg      <= '0;
            previous_vertex_reg <= '0;
        end
        else
        begin
            header_seen_reg     <= header_seen_next;
            face_counter_reg    <= face_counter_next;
            face_size_reg       <= face_size_next;
            hole_mark_reg       <= hole_mark_next;
            vertex_position_reg <= vertex_position_next;
            edge_base_reg       <= edge_base_next;
            fan_origin_reg      <= fan_origin_next;
            previous_vertex_reg <= previous_vertex_next;
        end
    end

endmodule

`default_nettype wire

// File: src/pfti_queue.sv
// Two-entry job queue between front and back
`default_nettype none

module pfti_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  pfti_pkg::job_t  push_data,
    input  wire             pop,
    output logic            full,
    output logic            not_empty,
    output pfti_pkg::job_t  head
);
    import pfti_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: src/pfti_back.sv
// Back end: winding, rotation, edge flag and edge index into the output register
`default_nettype none

module pfti_back (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               flip_winding,
    input  wire               job_valid,
    input  pfti_pkg::job_t    job_data,
    output logic              job_pop,
    output logic              result_valid,
    input  wire               result_ready,
    output pfti_pkg::result_t result_data
);
    import pfti_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    assign job_pop      = job_valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_ready)
            out_valid_next = 1'b0;
        if (job_pop)
            out_valid_next = 1'b1;

        out_data_next.source_face = job_data.face;
        out_data_next.corner_a    = job_data.origin;
        // unflipped: (first, current, previous)
        out_data_next.corner_b    = flip_winding ? job_data.prev : job_data.cur;
        out_data_next.corner_c    = flip_winding ? job_data.cur  : job_data.prev;
        out_data_next.edge_number = job_data.base + IndexBits'(job_data.tri_num)
                                  + IndexBits'(1);
        case (job_data.kind)
            FAN_SINGLE:
            begin
                out_data_next.hidden_edges = HideNone;
                out_data_next.edge_number  = job_data.base;
            end
            FAN_FIRST:
            begin
                out_data_next.hidden_edges = HideFirst;
                if (flip_winding)
                begin
                    // (b,c,a) of the flipped triangle
                    out_data_next.corner_a = job_data.prev;
                    out_data_next.corner_b = job_data.cur;
                    out_data_next.corner_c = job_data.origin;
                end
            end
            FAN_LAST:
            begin
                out_data_next.hidden_edges = HideLast;
                if (flip_winding)
                begin
                    // (c,a,b) of the flipped triangle
                    out_data_next.corner_a = job_data.cur;
                    out_data_next.corner_b = job_data.origin;
                    out_data_next.corner_c = job_data.prev;
                end
            end
            default:
                out_data_next.hidden_edges = HideBoth;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

endmodule

`default_nettype wire

// File: src/polygon_fan_triangle_indexer.sv
// A triangle is pushed into the job queue and then loaded into the result register once free.
// Throughput: one input word per cycle; the front stalls only when the two-entry
// job queue is full, which happens only while the result register is held by the sink.
// Reset (rst_n, asynchronous, active low) clears face state, queue, output valid
// and flip_winding; no clearing pass, the block takes words from the first cycle.
`default_nettype none

module polygon_fan_triangle_indexer (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  item_valid,
    output logic                                 item_ready,
    input  pfti_pkg::item_t                      item_data,
    output logic                                 result_valid,
    input  wire                                  result_ready,
    output pfti_pkg::result_t                    result_data,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [pfti_pkg::PaddrBits-1:0]        paddr,
    input  wire [pfti_pkg::PdataBits-1:0]        pwdata,
    output logic [pfti_pkg::PdataBits-1:0]       prdata,
    output logic                                 pready
);
    import pfti_pkg::*;

    logic flip_winding_reg, flip_winding_next;
    logic cfg_write;

    logic job_push;
    job_t job_in;
    logic queue_full;
    logic job_valid;
    job_t job_head;
    logic job_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == CfgAddrFlip);
    assign prdata    = (paddr == CfgAddrFlip) ? PdataBits'(flip_winding_reg) : '0;

    always_comb
    begin
        flip_winding_next = cfg_write ? pwdata[0] : flip_winding_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flip_winding_reg <= 1'b0;
        else
            flip_winding_reg <= flip_winding_next;
    end

    pfti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job_data   (job_in)
    );

    pfti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .pop       (job_pop),
        .full      (queue_full),
        .not_empty (job_valid),
        .head      (job_head)
    );

    pfti_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .flip_winding (flip_winding_reg),
        .job_valid    (job_valid),
        .job_data     (job_head),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

// File: src/pfti_checker.sv
// Port-level checker for the fan triangle indexer, bound to the top level
`default_nettype none

`include "polygon_fan_triangle_indexer_assert.svh"

module pfti_checker (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            item_ready,
    input  wire                            result_valid,
    input  wire                            result_ready,
    input  pfti_pkg::result_t              result_data,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [pfti_pkg::PaddrBits-1:0]  paddr,
    input  wire [pfti_pkg::PdataBits-1:0]  pwdata,
    input  wire [pfti_pkg::PdataBits-1:0]  prdata,
    input  wire                            pready
);
    import pfti_pkg::*;

    // a held result stays offered
    `PFTI_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
    // and keeps its word
    `PFTI_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result_data))
    // input back-pressure only comes from a stalled result
    `PFTI_ASSERT_NOW(a_stall_source, !item_ready, result_valid)
    // flip_winding reads back what was written
    `PFTI_ASSERT_NOW(a_flip_readback,
        $past(psel && penable && pwrite && pready && paddr == CfgAddrFlip)
            && paddr == CfgAddrFlip,
        prdata == PdataBits'($past(pwdata[0])))

endmodule

bind polygon_fan_triangle_indexer pfti_checker u_pfti_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the polygon fan triangle indexer: random faces, APB flip setting
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfti_pkg::*;

    localparam int unsigned CycleLimit = 600000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    item_t                item_data = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PaddrBits-1:0] paddr = '0;
    logic [PdataBits-1:0] pwdata = '0;
    logic [PdataBits-1:0] prdata;
    logic                 pready;

    polygon_fan_triangle_indexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    item_t       pending_words[$];
    result_t     fan_expected[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // predicted block state
    logic                 flip_cfg = 1'b0;
    logic                 seen_header = 1'b0;
    logic [FaceBits-1:0]  face_no = '0;
    logic [CountBits-1:0] cur_size = '0;
    logic [CountBits-1:0] vtx_pos = '0;
    logic                 in_hole = 1'b0;
    logic [IndexBits-1:0] base_edges = '0;
    logic [IndexBits-1:0] origin_vtx = '0;
    logic [IndexBits-1:0] last_vtx = '0;

    function automatic void predict_fan(input item_t w);
        result_t              fan;
        logic [CountBits-1:0] pos;
        logic [CountBits-1:0] j;
        logic [IndexBits-1:0] a;
        logic [IndexBits-1:0] b;
        logic [IndexBits-1:0] c;
        logic [IndexBits-1:0] t;
        fan = '0;
        if (w.func == FuncHeader)
        begin
            if (seen_header)
            begin
                face_no = face_no + FaceBits'(1);
                base_edges = base_edges + IndexBits'(cur_size);
            end
            seen_header = 1'b1;
            cur_size = w.face_vertex_count;
            in_hole = w.face_is_hole;
            vtx_pos = '0;
        end
        else if (seen_header && vtx_pos < cur_size)
        begin
            pos = vtx_pos;
            vtx_pos = vtx_pos + CountBits'(1);
            if (pos == 0)
            begin
                origin_vtx = w.vertex_index;
                last_vtx = w.vertex_index;
            end
            else if (pos == 1 || cur_size < 3 || in_hole)
                last_vtx = w.vertex_index;
            else
            begin
                j = pos - CountBits'(2);
                a = origin_vtx;
                b = flip_cfg ? last_vtx : w.vertex_index;
                c = flip_cfg ? w.vertex_index : last_vtx;
                if (cur_size > 3)
                begin
                    if (j == 0)
                    begin
                        fan.hidden_edges = HideFirst;
                        if (flip_cfg)
                        begin
                            t = a; a = b; b = c; c = t;
                        end
                    end
                    else if (j == cur_size - CountBits'(3))
                    begin
                        fan.hidden_edges = HideLast;
                        if (flip_cfg)
                        begin
                            t = c; c = b; b = a; a = t;
                        end
                    end
                    else
                        fan.hidden_edges = HideBoth;
                    fan.edge_number = base_edges + IndexBits'(j) + IndexBits'(1);
                end
                else
                begin
                    fan.hidden_edges = HideNone;
                    fan.edge_number = base_edges;
                end
                fan.corner_a = a;
                fan.corner_b = b;
                fan.corner_c = c;
                fan.source_face = face_no;
                last_vtx = w.vertex_index;
                fan_expected.push_back(fan);
            end
        end
    endfunction

    function automatic int unsigned pause_len(input bit calm);
        if (calm || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [IndexBits-1:0] any_index();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return IndexBits'($urandom());
    endfunction

    function automatic item_t header_word(input logic [CountBits-1:0] cnt, input logic hole);
        item_t w;
        w.func = FuncHeader;
        w.face_vertex_count = cnt;
        w.face_is_hole = hole;
        w.vertex_index = any_index();
        return w;
    endfunction

    function automatic item_t vertex_word(input logic [IndexBits-1:0] v);
        item_t w;
        w.func = FuncVertex;
        w.face_vertex_count = CountBits'($urandom());
        w.face_is_hole = 1'($urandom());
        w.vertex_index = v;
        return w;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // sender
    int unsigned tx_gap = 0;
    int unsigned items_taken = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_fan(item_data);
                items_taken++;
            end
            if (item_valid && !item_ready)
                ;
            else if (tx_gap != 0)
            begin
                item_valid <= 1'b0;
                tx_gap--;
            end
            else if (pending_words.size() != 0)
            begin
                item_data <= pending_words.pop_front();
                item_valid <= 1'b1;
                tx_gap = pause_len((items_taken % 256) < 48);
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver and checker
    int unsigned rx_wait = 0;
    int unsigned hold_left = 0;
    int unsigned tris_checked = 0;

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (fan_expected.size() == 0)
                begin
                    $display("%0t: expected none, got %0d %0d %0d f%0d h%0d e%0d",
                             $time, result_data.corner_a, result_data.corner_b,
                             result_data.corner_c, result_data.source_face,
                             result_data.hidden_edges, result_data.edge_number);
                    mismatches++;
                end
                else
                begin
                    want = fan_expected.pop_front();
                    check_field("corner_a", 32'(want.corner_a), 32'(result_data.corner_a));
                    check_field("corner_b", 32'(want.corner_b), 32'(result_data.corner_b));
                    check_field("corner_c", 32'(want.corner_c), 32'(result_data.corner_c));
                    check_field("source_face", 32'(want.source_face),
                                32'(result_data.source_face));
                    check_field("hidden_edges", 32'(want.hidden_edges),
                                32'(result_data.hidden_edges));
                    check_field("edge_number", 32'(want.edge_number),
                                32'(result_data.edge_number));
                end
                tris_checked++;
                // long back-pressure so the job queue fills and the input stalls
                if (tris_checked == 100 || tris_checked == 500)
                    hold_left = 250;
                rx_wait = pause_len((tris_checked % 128) < 24);
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (rx_wait != 0)
            begin
                rx_wait--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("%0t: cycle limit hit, %0d triangles still awaited",
                     $time, fan_expected.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // register write, then read back
    task automatic set_flip(input logic v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CfgAddrFlip;
        pwdata <= PdataBits'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        flip_cfg = v;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PdataBits'(v))
        begin
            $display("%0t: flip_winding read expected %0d got %0d", $time, v, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // status is looked at on the falling edge, after the rising-edge updates settle
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_words.size() != 0 || item_valid || fan_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_directed();
        pending_words.push_back(vertex_word('1));          // stray word before any header
        pending_words.push_back(header_word(16'd3, 1'b0));
        pending_words.push_back(vertex_word('0));
        pending_words.push_back(vertex_word('1));
        pending_words.push_back(vertex_word(any_index()));
        pending_words.push_back(header_word(16'd4, 1'b0));
        repeat (5) pending_words.push_back(vertex_word(any_index()));   // one past the count
        pending_words.push_back(header_word(16'd4, 1'b1));
        repeat (4) pending_words.push_back(vertex_word(any_index()));
        pending_words.push_back(header_word(16'd2, 1'b0));
        repeat (2) pending_words.push_back(vertex_word(any_index()));
        pending_words.push_back(header_word(16'd0, 1'b0));
        pending_words.push_back(vertex_word(any_index()));
        pending_words.push_back(header_word(16'hFFFF, 1'b0));
        repeat (3) pending_words.push_back(vertex_word(any_index()));
    endtask

    task automatic queue_random_faces(input int unsigned target);
        int unsigned          queued;
        int unsigned          kind;
        int unsigned          n;
        int unsigned          extra;
        logic [CountBits-1:0] cnt;
        logic                 hole;
        queued = 0;
        while (queued < target)
        begin
            kind = $urandom_range(0, 99);
            extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
            hole = 1'b0;
            if (kind < 72)
            begin
                if ($urandom_range(0, 4) == 0)
                    cnt = 16'd3;
                else if ($urandom_range(0, 19) == 0)
                    cnt = CountBits'($urandom_range(13, 40));
                else
                    cnt = CountBits'($urandom_range(4, 12));
                hole = ($urandom_range(0, 9) == 0);
                n = 32'(cnt);
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(0, cnt - 1);
            end
            else if (kind < 82)
            begin
                cnt = CountBits'($urandom_range(0, 2));
                hole = 1'($urandom());
                n = 32'(cnt);
            end
            else if (kind < 90)
            begin
                // huge count, cut short by the next header
                cnt = CountBits'($urandom_range(0, 16'hFFFF));
                n = $urandom_range(0, 6);
                extra = 0;
            end
            else
            begin
                repeat ($urandom_range(1, 3)) pending_words.push_back(vertex_word(any_index()));
                continue;
            end
            pending_words.push_back(header_word(cnt, hole));
            repeat (n + extra) pending_words.push_back(vertex_word(any_index()));
            queued += 1 + n;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_flip(1'b0);
        queue_directed();
        queue_random_faces(400);
        wait_idle();

        set_flip(1'b1);
        queue_directed();
        queue_random_faces(400);
        wait_idle();

        set_flip(1'b0);
        queue_random_faces(450);
        wait_idle();

        set_flip(1'b1);
        queue_random_faces(450);
        wait_idle();

        if (mismatches == 0 && fan_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
+incdir+src
src/pfti_pkg.sv
src/pfti_front.sv
src/pfti_queue.sv
src/pfti_back.sv
src/polygon_fan_triangle_indexer.sv
src/pfti_checker.sv
verif/tb_top.sv
